>>> rtl/lpe_pkg.sv
// Shared types and constants of the line position error estimator.
// Depends on nothing; every other file but lpe_fifo refers to it by scoped names.
package lpe_pkg;

	localparam int SAMPLE_FIELD_BITS = 10;
	localparam int DIST_BITS         = 10;
	localparam int WEIGHT_BITS       = 8;
	localparam int SCALE_BITS        = 12;
	localparam int TOTAL_BITS        = 12;
	localparam int LOST_BITS         = 19;
	localparam int ERROR_BITS        = 20;
	localparam int PRODUCT_BITS      = 19;
	localparam int WSUM_BITS         = 20;
	localparam int SCALED_BITS       = 32;
	localparam int DIVIDEND_BITS     = 31;
	localparam int CFG_INDEX_BITS    = 3;
	localparam int CFG_DATA_BITS     = 19;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LEFT_WT       = 3'd0,
		REG_MID_WT        = 3'd1,
		REG_RIGHT_WT      = 3'd2,
		REG_ERR_GAIN      = 3'd3,
		REG_MIN_TOTAL     = 3'd4,
		REG_LOST_ERROR    = 3'd5,
		REG_STOP_DISTANCE = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_ERROR   = 2'd0,
		KIND_STOP    = 2'd1,
		KIND_TIMEOUT = 2'd2
	} report_kind_t;

	// Direction of the last computed error
	typedef enum logic [1:0] {
		SIGN_NONE = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2
	} sign_t;

	// What the back end has to do with a queued job
	typedef enum logic [2:0] {
		JOB_STOP,
		JOB_TIMEOUT,
		JOB_LOST,
		JOB_ZERO,
		JOB_CALC
	} job_kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DECIDE,
		B_MUL,
		B_SUM,
		B_SCALE,
		B_START,
		B_DIV,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic                         distance_valid;
		logic [DIST_BITS-1:0]         distance;
		logic                         adc_ok;
		logic [SAMPLE_FIELD_BITS-1:0] left_sample;
		logic [SAMPLE_FIELD_BITS-1:0] mid_sample;
		logic [SAMPLE_FIELD_BITS-1:0] right_sample;
	} sense_word_t;

	typedef struct packed {
		report_kind_t                  report_kind;
		logic signed [ERROR_BITS-1:0]  error_value;
	} report_word_t;

	typedef struct packed {
		logic signed [WEIGHT_BITS-1:0] left_wt;
		logic signed [WEIGHT_BITS-1:0] mid_wt;
		logic signed [WEIGHT_BITS-1:0] right_wt;
		logic [SCALE_BITS-1:0]         err_gain;
		logic [TOTAL_BITS-1:0]         min_total;
		logic [LOST_BITS-1:0]          lost_error;
		logic [DIST_BITS-1:0]          stop_distance;
	} cfg_t;

	typedef struct packed {
		job_kind_t                    kind;
		logic [SAMPLE_FIELD_BITS-1:0] left_sample;
		logic [SAMPLE_FIELD_BITS-1:0] mid_sample;
		logic [SAMPLE_FIELD_BITS-1:0] right_sample;
		logic [TOTAL_BITS-1:0]        total;
	} job_t;

endpackage

>>> rtl/line_position_error_estimator_unit.sv
// Line position error estimator, top level: config registers, front end,
// job queue, back end and report queue. Uses lpe_pkg, lpe_front, lpe_fifo, lpe_back.
// Stop, timeout, lost-line and zero-total jobs pass the back end's decide and output
// states; a computed error also passes multiply, sum, scale, start and the 31-step
// restoring divider. The back end starts a job only after pushing the last report.
// Reset clears the queues, the sequencer and the last direction, and returns
// all configuration registers to their defaults.
module line_position_error_estimator_unit #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  lpe_pkg::sense_word_t                 sense,
	output logic                                 empty,
	input  logic                                 pop,
	output lpe_pkg::report_word_t                report,
	input  logic                                 cfg_wr_en,
	input  logic [lpe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [lpe_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	lpe_pkg::cfg_t         cfg_q;
	lpe_pkg::job_t         job_new;
	lpe_pkg::job_t         job_rd;
	logic [$bits(lpe_pkg::job_t)-1:0]         job_rd_bits;
	logic [$bits(lpe_pkg::report_word_t)-1:0] report_bits;
	logic                  job_empty;
	logic                  job_pop;
	logic                  res_full;
	logic                  res_push;
	lpe_pkg::report_word_t res_word;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_wt       <= -8'sd1;
			cfg_q.mid_wt        <= 8'sd0;
			cfg_q.right_wt      <= 8'sd1;
			cfg_q.err_gain      <= 12'd1000;
			cfg_q.min_total     <= 12'd300;
			cfg_q.lost_error    <= 19'd1000;
			cfg_q.stop_distance <= 10'd20;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				lpe_pkg::REG_LEFT_WT:       cfg_q.left_wt       <= cfg_data[7:0];
				lpe_pkg::REG_MID_WT:        cfg_q.mid_wt        <= cfg_data[7:0];
				lpe_pkg::REG_RIGHT_WT:      cfg_q.right_wt      <= cfg_data[7:0];
				lpe_pkg::REG_ERR_GAIN:      cfg_q.err_gain      <= cfg_data[11:0];
				lpe_pkg::REG_MIN_TOTAL:     cfg_q.min_total     <= cfg_data[11:0];
				lpe_pkg::REG_LOST_ERROR:    cfg_q.lost_error    <= cfg_data[18:0];
				lpe_pkg::REG_STOP_DISTANCE: cfg_q.stop_distance <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	lpe_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.sense (sense),
		.cfg   (cfg_q),
		.job   (job_new)
	);

	// job queue between front and back
	lpe_fifo #(
		.WIDTH      ($bits(lpe_pkg::job_t)),
		.DEPTH_LOG2 (1)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (job_new),
		.full    (full),
		.pop     (job_pop),
		.rd_data (job_rd_bits),
		.empty   (job_empty)
	);

	assign job_rd = lpe_pkg::job_t'(job_rd_bits);

	lpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job_rd    (job_rd),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_word  (res_word)
	);

	// report queue towards the consumer
	lpe_fifo #(
		.WIDTH      ($bits(lpe_pkg::report_word_t)),
		.DEPTH_LOG2 (1)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_word),
		.full    (res_full),
		.pop     (pop),
		.rd_data (report_bits),
		.empty   (empty)
	);

	assign report = lpe_pkg::report_word_t'(report_bits);

	// checks
	a_stop_or_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && report.report_kind != lpe_pkg::KIND_ERROR) |-> (report.error_value == '0))
		else $error("non-error report carries a non-zero error value");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (report.report_kind == lpe_pkg::KIND_ERROR
			|| report.report_kind == lpe_pkg::KIND_STOP
			|| report.report_kind == lpe_pkg::KIND_TIMEOUT))
		else $error("report kind code out of range");

	a_job_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !job_empty)
		else $error("accepted word missing from the job queue");

	a_pop_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !job_empty)
		else $error("back end popped an empty job queue");

endmodule

>>> rtl/lpe_fifo.sv
// Small register queue of fixed-width words with full and empty flags.
// Depends on nothing; used for the job queue and the report queue.
module lpe_fifo #(
	parameter int WIDTH      = 8,
	parameter int DEPTH_LOG2 = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [WIDTH-1:0]      mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wr_ptr_q;
	logic [DEPTH_LOG2-1:0] rd_ptr_q;
	logic [DEPTH_LOG2:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == (DEPTH_LOG2+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

>>> rtl/lpe_front.sv
// Front end: masks the samples, forms their total and classifies the word.
// Depends on lpe_pkg.
module lpe_front #(
	parameter int SAMPLE_BITS = 10
) (
	input  lpe_pkg::sense_word_t sense,
	input  lpe_pkg::cfg_t        cfg,
	output lpe_pkg::job_t        job
);

	localparam logic [lpe_pkg::SAMPLE_FIELD_BITS-1:0] SMASK =
		lpe_pkg::SAMPLE_FIELD_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

	logic [lpe_pkg::SAMPLE_FIELD_BITS-1:0] l;
	logic [lpe_pkg::SAMPLE_FIELD_BITS-1:0] m;
	logic [lpe_pkg::SAMPLE_FIELD_BITS-1:0] r;
	logic [lpe_pkg::TOTAL_BITS-1:0]        total;

	assign l = sense.left_sample & SMASK;
	assign m = sense.mid_sample & SMASK;
	assign r = sense.right_sample & SMASK;
	assign total = lpe_pkg::TOTAL_BITS'(l) + lpe_pkg::TOTAL_BITS'(m)
		+ lpe_pkg::TOTAL_BITS'(r);

	// classification; obstacle test has priority, then ADC failure
	always_comb begin
		job.left_sample  = l;
		job.mid_sample   = m;
		job.right_sample = r;
		job.total        = total;
		if (sense.distance_valid && (sense.distance < cfg.stop_distance))
			job.kind = lpe_pkg::JOB_STOP;
		else if (!sense.adc_ok)
			job.kind = lpe_pkg::JOB_TIMEOUT;
		else if (total < cfg.min_total)
			job.kind = lpe_pkg::JOB_LOST;
		else if (total == '0)
			job.kind = lpe_pkg::JOB_ZERO;
		else
			job.kind = lpe_pkg::JOB_CALC;
	end

endmodule

>>> rtl/lpe_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lpe_pkg for the operand widths.
module lpe_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [lpe_pkg::DIVIDEND_BITS-1:0]   dividend,
	input  logic [lpe_pkg::TOTAL_BITS-1:0]      divisor,
	output logic                                done,
	output logic [lpe_pkg::DIVIDEND_BITS-1:0]   quotient
);

	localparam int DW = lpe_pkg::DIVIDEND_BITS;
	localparam int VW = lpe_pkg::TOTAL_BITS;
	localparam int CW = $clog2(DW);

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   rem_sh;
	logic [VW+1:0] diff;
	logic          q_bit;

	// one trial subtraction
	assign rem_sh = {rem_q, dvd_q[DW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, div_q};
	assign q_bit  = ~diff[VW+1];

	assign done     = done_q;
	assign quotient = dvd_q;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], q_bit};
			rem_q <= q_bit ? diff[VW-1:0] : rem_sh[VW-1:0];
		end
	end

endmodule

>>> rtl/lpe_back.sv
// Back end: takes jobs from the queue, runs the weighted-sum arithmetic and
// the divider, tracks the last direction and hands reports on. Uses lpe_pkg, lpe_div.
module lpe_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpe_pkg::cfg_t         cfg,
	input  logic                  job_empty,
	input  lpe_pkg::job_t         job_rd,
	output logic                  job_pop,
	input  logic                  res_full,
	output logic                  res_push,
	output lpe_pkg::report_word_t res_word
);

	lpe_pkg::back_state_t state_q;
	lpe_pkg::back_state_t state_d;
	lpe_pkg::job_t        job_q;
	lpe_pkg::sign_t       last_sign_q;
	lpe_pkg::report_word_t result_q;

	logic signed [lpe_pkg::PRODUCT_BITS-1:0] p_l_q;
	logic signed [lpe_pkg::PRODUCT_BITS-1:0] p_m_q;
	logic signed [lpe_pkg::PRODUCT_BITS-1:0] p_r_q;
	logic signed [lpe_pkg::WSUM_BITS-1:0]    ws_q;
	logic signed [lpe_pkg::SCALED_BITS-1:0]  prod_q;
	logic [lpe_pkg::SCALED_BITS-1:0]         prod_abs;
	logic                                    div_start;
	logic                                    div_done;
	logic [lpe_pkg::DIVIDEND_BITS-1:0]       quotient;
	logic [lpe_pkg::ERROR_BITS-1:0]          q_low;
	logic [lpe_pkg::ERROR_BITS-1:0]          err_calc;
	lpe_pkg::sign_t                          sign_calc;
	logic [lpe_pkg::ERROR_BITS-1:0]          lost_mag;
	logic [lpe_pkg::ERROR_BITS-1:0]          lost_val;

	lpe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_abs[lpe_pkg::DIVIDEND_BITS-1:0]),
		.divisor  (job_q.total),
		.done     (div_done),
		.quotient (quotient)
	);

	// magnitude of the scaled sum; the sign is restored after division
	assign prod_abs = prod_q[lpe_pkg::SCALED_BITS-1] ? ('0 - prod_q) : prod_q;
	assign q_low    = quotient[lpe_pkg::ERROR_BITS-1:0];
	assign err_calc = prod_q[lpe_pkg::SCALED_BITS-1] ? ('0 - q_low) : q_low;
	assign sign_calc = (quotient == '0) ? lpe_pkg::SIGN_NONE :
		(prod_q[lpe_pkg::SCALED_BITS-1] ? lpe_pkg::SIGN_NEG : lpe_pkg::SIGN_POS);

	// lost line: follow the last direction, code 3 counts as none
	assign lost_mag = {1'b0, cfg.lost_error};
	always_comb begin
		case (last_sign_q)
			lpe_pkg::SIGN_POS: lost_val = lost_mag;
			lpe_pkg::SIGN_NEG: lost_val = '0 - lost_mag;
			default:           lost_val = '0;
		endcase
	end

	assign res_word = result_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lpe_pkg::B_IDLE;
		else         state_q <= state_d;
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		res_push  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			lpe_pkg::B_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = lpe_pkg::B_DECIDE;
				end
			end
			lpe_pkg::B_DECIDE: begin
				state_d = (job_q.kind == lpe_pkg::JOB_CALC) ? lpe_pkg::B_MUL : lpe_pkg::B_OUT;
			end
			lpe_pkg::B_MUL:   state_d = lpe_pkg::B_SUM;
			lpe_pkg::B_SUM:   state_d = lpe_pkg::B_SCALE;
			lpe_pkg::B_SCALE: state_d = lpe_pkg::B_START;
			lpe_pkg::B_START: begin
				div_start = 1'b1;
				state_d   = lpe_pkg::B_DIV;
			end
			lpe_pkg::B_DIV: begin
				if (div_done) state_d = lpe_pkg::B_OUT;
			end
			lpe_pkg::B_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = lpe_pkg::B_IDLE;
				end
			end
			default: state_d = lpe_pkg::B_IDLE;
		endcase
	end

	// last direction seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sign_q <= lpe_pkg::SIGN_NONE;
		end else if (state_q == lpe_pkg::B_DECIDE && job_q.kind == lpe_pkg::JOB_ZERO) begin
			last_sign_q <= lpe_pkg::SIGN_NONE;
		end else if (state_q == lpe_pkg::B_DIV && div_done) begin
			last_sign_q <= sign_calc;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lpe_pkg::B_IDLE: begin
				if (job_pop) job_q <= job_rd;
			end
			lpe_pkg::B_DECIDE: begin
				result_q.error_value <= '0;
				case (job_q.kind)
					lpe_pkg::JOB_STOP:    result_q.report_kind <= lpe_pkg::KIND_STOP;
					lpe_pkg::JOB_TIMEOUT: result_q.report_kind <= lpe_pkg::KIND_TIMEOUT;
					lpe_pkg::JOB_LOST: begin
						result_q.report_kind <= lpe_pkg::KIND_ERROR;
						result_q.error_value <= lost_val;
					end
					default:              result_q.report_kind <= lpe_pkg::KIND_ERROR;
				endcase
			end
			lpe_pkg::B_MUL: begin
				p_l_q <= $signed({1'b0, job_q.left_sample}) * $signed(cfg.left_wt);
				p_m_q <= $signed({1'b0, job_q.mid_sample}) * $signed(cfg.mid_wt);
				p_r_q <= $signed({1'b0, job_q.right_sample}) * $signed(cfg.right_wt);
			end
			lpe_pkg::B_SUM: ws_q <= p_l_q + p_m_q + p_r_q;
			lpe_pkg::B_SCALE: prod_q <= ws_q * $signed({1'b0, cfg.err_gain});
			lpe_pkg::B_DIV: begin
				if (div_done) begin
					result_q.report_kind <= lpe_pkg::KIND_ERROR;
					result_q.error_value <= err_calc;
				end
			end
			default: ;
		endcase
	end

endmodule
